FILE: sv/sorted_leaf_page_engine_core_macros.svh
// Assertion macros for the sorted leaf page engine.
// Used by the top level and the back part; no dependencies.
`ifndef SORTED_LEAF_PAGE_ENGINE_CORE_MACROS_SVH
`define SORTED_LEAF_PAGE_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SLP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("slp assertion");
`define SLP_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("slp assertion");
`else
`define SLP_ASSERT(lbl, clk, rst_n, prop)
`define SLP_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

FILE: sv/slpe_pkg.sv
// Package for the sorted leaf page engine: payload words, codes and sizes.
// No dependencies.
package slpe_pkg;
  localparam int unsigned Capacity = 32;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned SplitMin = 2;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_SPLIT  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_SPLIT,
    ST_SINGLE
  } back_state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic [30:0]        value_page;
    logic [15:0]        value_slot;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] out_key;
    logic [30:0]        out_page;
    logic [15:0]        out_slot;
    logic [5:0]         entry_count;
    logic               last;
  } out_word_t;

  // classified command from front to back
  typedef struct packed {
    action_e            action;
    logic signed [31:0] key;
    logic [30:0]        value_page;
    logic [15:0]        value_slot;
    logic               refuse;
  } cmd_t;
endpackage

FILE: sv/sorted_leaf_page_engine_core.sv
// Sorted leaf page engine (one B+ tree leaf page), top level.
// Depends on slpe_pkg, slpe_front, slpe_back, slpe_outq and the macros header.
//
// Holds up to 32 entries sorted by signed key. One word is in work at a time:
// the front takes it, decides refusal against max_entries, and hands it on;
// the back then runs the sorted cell array. Insert goes through accept,
// hand-over and one parallel shift of every cell. Lookup walks the page one
// slot per cycle, holding on a match while the result queue is full, and
// emits each match as it passes. Split streams count/2 entries, one per
// cycle while the queue has room. A two-word result queue decouples pop; a full queue stalls the back part.
`include "sorted_leaf_page_engine_core_macros.svh"
module sorted_leaf_page_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  slpe_pkg::in_word_t  in_word_i,
  output logic                empty_o,
  input  logic                pop_i,
  output slpe_pkg::out_word_t out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [5:0] max_entries_q;
  logic [slpe_pkg::CntW-1:0] count;
  logic back_idle, cmd_valid, cmd_take, res_valid, res_room;
  slpe_pkg::cmd_t cmd;
  slpe_pkg::out_word_t res;

  // configuration: one register at address zero
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {26'd0, max_entries_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= 6'd32;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      max_entries_q <= pwdata[5:0];
    end
  end

  slpe_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .in_word_i,
    .max_entries_i(max_entries_q), .count_i(count), .back_idle_i(back_idle),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  slpe_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .idle_o(back_idle), .count_o(count), .res_valid_o(res_valid), .res_o(res),
    .res_room_i(res_room)
  );

  slpe_outq u_outq (
    .clk_i, .rst_ni, .wr_i(res_valid), .wdata_i(res), .room_o(res_room),
    .pop_i, .empty_o, .rdata_o(out_word_o)
  );

  `SLP_ASSERT(a_no_push_when_busy, clk_i, rst_ni, cmd_valid |-> full_o)
  `SLP_ASSERT(a_cfg_kept, clk_i, rst_ni,
    !(psel && penable && pwrite) |=> $stable(max_entries_q))
  `SLP_ASSERT(a_count_ok, clk_i, rst_ni, count <= slpe_pkg::CntW'(slpe_pkg::Capacity))
endmodule

FILE: sv/slpe_front.sv
// Front part: takes input words, checks the fill limit, holds one command for the back.
// Depends on slpe_pkg.
module slpe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  slpe_pkg::in_word_t in_word_i,
  input  logic [5:0]        max_entries_i,
  input  logic [slpe_pkg::CntW-1:0] count_i,
  input  logic              back_idle_i,
  output logic              cmd_valid_o,
  output slpe_pkg::cmd_t    cmd_o,
  input  logic              cmd_take_i
);
  // one item at a time: count must be settled before classifying
  logic busy_q, busy_d;
  logic [slpe_pkg::CntW-1:0] limit;
  slpe_pkg::cmd_t cmd_q;

  assign limit = (max_entries_i > 6'(slpe_pkg::Capacity)) ?
                 slpe_pkg::CntW'(slpe_pkg::Capacity) : slpe_pkg::CntW'(max_entries_i);
  assign full_o = busy_q || !back_idle_i;

  always_comb begin
    busy_d = busy_q;
    if (push_i && !full_o) busy_d = 1'b1;
    else if (cmd_take_i) busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      cmd_q.action     <= slpe_pkg::action_e'(in_word_i.action);
      cmd_q.key        <= in_word_i.key;
      cmd_q.value_page <= in_word_i.value_page;
      cmd_q.value_slot <= in_word_i.value_slot;
      cmd_q.refuse     <= (count_i >= limit);
    end
  end

  assign cmd_valid_o = busy_q;
  assign cmd_o = cmd_q;
endmodule

FILE: sv/slpe_back.sv
// Back part: shifts the sorted cell array, scans matches, streams a split.
// Depends on slpe_pkg and the macros header.
`include "sorted_leaf_page_engine_core_macros.svh"
module slpe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  slpe_pkg::cmd_t     cmd_i,
  output logic               cmd_take_o,
  output logic               idle_o,
  output logic [slpe_pkg::CntW-1:0] count_o,
  output logic               res_valid_o,
  output slpe_pkg::out_word_t res_o,
  input  logic               res_room_i
);
  localparam int unsigned N = slpe_pkg::Capacity;
  localparam int unsigned IW = slpe_pkg::IdxW;
  localparam int unsigned CW = slpe_pkg::CntW;

  slpe_pkg::back_state_e state_q, state_d;
  logic signed [31:0] keys_q [N];
  logic [46:0]        recs_q [N];
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d, end_q, end_d;
  logic found_q, found_d;
  slpe_pkg::cmd_t cmd_q;
  logic take;
  logic [N-1:0] less;
  logic [IW-1:0] ridx;
  logic hit, more;

  assign take = (state_q == slpe_pkg::ST_IDLE) && cmd_valid_i;
  assign cmd_take_o = take;
  assign idle_o = (state_q == slpe_pkg::ST_IDLE) && !cmd_valid_i;
  assign count_o = count_q;
  assign ridx = idx_q[IW-1:0];
  assign hit = (keys_q[ridx] == cmd_q.key);
  assign more = (idx_q + CW'(1)) < end_q;

  // one compare per cell: entry moves up when its key is not below the new key
  always_comb begin
    for (int i = 0; i < N; i++) begin
      less[i] = (CW'(i) < count_q) && (keys_q[i] < cmd_q.key);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slpe_pkg::ST_IDLE: begin
        if (take) begin
          unique case (cmd_i.action)
            slpe_pkg::ACT_INSERT: state_d = cmd_i.refuse ?
                                  slpe_pkg::ST_SINGLE : slpe_pkg::ST_SHIFT;
            slpe_pkg::ACT_LOOKUP: state_d = (count_q == '0) ?
                                  slpe_pkg::ST_SINGLE : slpe_pkg::ST_SCAN;
            slpe_pkg::ACT_SPLIT:  state_d = (count_q < CW'(slpe_pkg::SplitMin)) ?
                                  slpe_pkg::ST_SINGLE : slpe_pkg::ST_SPLIT;
            default:              state_d = slpe_pkg::ST_SINGLE;
          endcase
        end
      end
      slpe_pkg::ST_SHIFT:  if (res_room_i) state_d = slpe_pkg::ST_IDLE;
      slpe_pkg::ST_SINGLE: if (res_room_i) state_d = slpe_pkg::ST_IDLE;
      slpe_pkg::ST_SCAN: begin
        if (!more && (hit || found_q || res_room_i)) begin
          if (res_room_i || !(hit || !found_q)) state_d = slpe_pkg::ST_IDLE;
        end
      end
      slpe_pkg::ST_SPLIT:  if (res_room_i && !more) state_d = slpe_pkg::ST_IDLE;
      default:             state_d = slpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    end_d = end_q;
    found_d = found_q;
    count_d = count_q;
    res_valid_o = 1'b0;
    res_o = '0;
    res_o.entry_count = 6'(count_q);
    res_o.last = 1'b1;
    unique case (state_q)
      slpe_pkg::ST_IDLE: begin
        found_d = 1'b0;
        if (take && cmd_i.action == slpe_pkg::ACT_SPLIT) begin
          idx_d = count_q - (count_q >> 1);
          end_d = count_q;
        end else begin
          idx_d = '0;
          end_d = count_q;
        end
      end
      slpe_pkg::ST_SHIFT: begin
        res_valid_o = 1'b1;
        res_o.ok = 1'b1;
        res_o.out_key = cmd_q.key;
        res_o.entry_count = 6'(count_q + CW'(1));
        if (res_room_i) count_d = count_q + CW'(1);
      end
      slpe_pkg::ST_SINGLE: begin
        res_valid_o = 1'b1;
        res_o.out_key = (cmd_q.action == slpe_pkg::ACT_INSERT ||
                         cmd_q.action == slpe_pkg::ACT_LOOKUP) ? cmd_q.key : '0;
      end
      slpe_pkg::ST_SCAN: begin
        res_o.out_key = cmd_q.key;
        if (hit) begin
          res_valid_o = 1'b1;
          res_o.ok = 1'b1;
          res_o.out_page = recs_q[ridx][46:16];
          res_o.out_slot = recs_q[ridx][15:0];
          res_o.last = 1'b0;
          // last only known when no later entry matches: look one ahead
          if (!more) res_o.last = 1'b1;
          else if (keys_q[IW'(idx_q + CW'(1))] != cmd_q.key) res_o.last = 1'b1;
          if (res_room_i) begin
            found_d = 1'b1;
            idx_d = idx_q + CW'(1);
          end
        end else if (!more && !found_q) begin
          res_valid_o = 1'b1;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      slpe_pkg::ST_SPLIT: begin
        res_valid_o = 1'b1;
        res_o.ok = 1'b1;
        res_o.out_key = keys_q[ridx];
        res_o.out_page = recs_q[ridx][46:16];
        res_o.out_slot = recs_q[ridx][15:0];
        res_o.last = !more;
        res_o.entry_count = 6'(end_q - (end_q >> 1));
        if (res_room_i) begin
          idx_d = idx_q + CW'(1);
          if (!more) count_d = end_q - (end_q >> 1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slpe_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      end_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
  end

  // cell array: each cell keeps, loads from below, or takes the new entry
  always_ff @(posedge clk_i) begin
    if (state_q == slpe_pkg::ST_SHIFT && res_room_i) begin
      for (int i = 0; i < N; i++) begin
        if (!less[i]) begin
          if (i == 0 || less[(i == 0) ? 0 : i - 1]) begin
            keys_q[i] <= cmd_q.key;
            recs_q[i] <= {cmd_q.value_page, cmd_q.value_slot};
          end else begin
            keys_q[i] <= keys_q[(i == 0) ? 0 : i - 1];
            recs_q[i] <= recs_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end
  end

  `SLP_ASSERT(a_count_cap, clk_i, rst_ni, count_q <= CW'(N))
  `SLP_ASSERT(a_take_idle, clk_i, rst_ni, take |=> state_q != slpe_pkg::ST_IDLE)
  `SLP_ASSERT(a_split_shrinks, clk_i, rst_ni,
    (state_q == slpe_pkg::ST_SPLIT && state_d == slpe_pkg::ST_IDLE) |=> count_q < $past(end_q))
endmodule

FILE: sv/slpe_outq.sv
// Result queue: two-entry buffer between the back part and the pop side.
// Depends on slpe_pkg.
module slpe_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  slpe_pkg::out_word_t wdata_i,
  output logic                room_o,
  input  logic                pop_i,
  output logic                empty_o,
  output slpe_pkg::out_word_t rdata_o
);
  slpe_pkg::out_word_t buf_q [slpe_pkg::QDepth];
  logic rp_q, wp_q;
  logic [1:0] n_q;
  logic rd, wr;

  assign room_o = n_q < 2'(slpe_pkg::QDepth);
  assign empty_o = (n_q == 2'd0);
  assign rd = pop_i && !empty_o;
  assign wr = wr_i && room_o;
  assign rdata_o = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0;
      wp_q <= 1'b0;
      n_q  <= '0;
    end else begin
      if (rd) rp_q <= !rp_q;
      if (wr) wp_q <= !wp_q;
      n_q <= n_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) buf_q[wp_q] <= wdata_i;
  end
endmodule
